// ===== design/palette_run_length_encoder_unit_assert.svh =====
// Assertion macros for the palette run-length encoder.
// Needs nothing else; included by palette_run_length_encoder_unit.sv, the file that checks its own logic.
`ifndef PALETTE_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH
`define PALETTE_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prle: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prle: next-cycle check failed");

`endif

// ===== design/prle_pkg.sv =====
// Shared types and constants of the palette run-length encoder.
// No dependencies; imported by every module except the generic RAM.
package prle_pkg;

    localparam int PALETTE_SIZE = 64;
    localparam int RUN_BITS     = 24;
    localparam int COLOR_BITS   = 24;

    // fixed field widths at the ports
    localparam int PIX_W     = 24;
    localparam int IDX_OUT_W = 6;
    localparam int LEN_W     = 24;

    localparam int COLOR_W = (COLOR_BITS < PIX_W) ? COLOR_BITS : PIX_W;
    localparam int IDX_W   = $clog2(PALETTE_SIZE);
    localparam int CNT_W   = $clog2(PALETTE_SIZE + 1);

    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    localparam logic FUNC_PALETTE = 1'b0;
    localparam logic FUNC_ENCODE  = 1'b1;

    typedef enum logic [1:0] {
        K_ENTRY   = 2'd0,
        K_RUN     = 2'd1,
        K_PAL_OVF = 2'd2,
        K_RUN_OVF = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_LAST
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic [PIX_W-1:0]     color;
        logic [IDX_OUT_W-1:0] index;
        logic [LEN_W-1:0]     run_length;
        logic                 eoo;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result data;
    } t_push;

endpackage

// ===== design/prle_palette_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the colour palette.
module prle_palette_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/prle_out_fifo.sv =====
// Two-entry result queue between the controller and the output channel.
// Depends on prle_pkg for the result type.
module prle_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prle_pkg::t_push   i_push,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output prle_pkg::t_result o_head
);
    import prle_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            wr;
    logic            rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr      = i_push.push && !o_full;
    assign rd      = o_valid && !i_stall;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= AW'(r_wptr + 1'b1);
            end
            if (rd) begin
                r_rptr <= AW'(r_rptr + 1'b1);
            end
            if (wr && !rd) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (rd && !wr) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// ===== design/prle_ctrl.sv =====
// Sequencer: palette scan over the RAM, palette insert, run tracking, result pushes.
// Depends on prle_pkg; drives prle_palette_ram and prle_out_fifo.
module prle_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic [prle_pkg::PIX_W-1:0]   i_pixel,
    input  logic                         i_last,
    output logic                         o_ram_we,
    output logic [prle_pkg::IDX_W-1:0]   o_ram_waddr,
    output logic [prle_pkg::COLOR_W-1:0] o_ram_wdata,
    output logic                         o_ram_re,
    output logic [prle_pkg::IDX_W-1:0]   o_ram_raddr,
    input  logic [prle_pkg::COLOR_W-1:0] i_ram_rdata,
    output prle_pkg::t_push              o_push,
    input  logic                         i_fifo_full
);
    import prle_pkg::*;

    t_state                r_state,     n_state;
    logic                  r_func,      n_func;
    logic [COLOR_W-1:0]    r_pix,       n_pix;
    logic                  r_last,      n_last;
    logic [CNT_W-1:0]      r_addr,      n_addr;
    logic [IDX_W-1:0]      r_rd_addr,   n_rd_addr;
    logic                  r_rd_vld,    n_rd_vld;
    logic                  r_found,     n_found;
    logic [IDX_W-1:0]      r_idx,       n_idx;
    logic [CNT_W-1:0]      r_pal_cnt,   n_pal_cnt;
    logic [COLOR_W-1:0]    r_run_color, n_run_color;
    logic [IDX_OUT_W-1:0]  r_run_index, n_run_index;
    logic [RUN_BITS-1:0]   r_run_count, n_run_count;
    logic                  r_run_open,  n_run_open;
    logic                  hit;
    logic                  same_run;

    // compare of the entry read in the previous cycle
    assign hit      = r_rd_vld && (i_ram_rdata == r_pix);
    assign same_run = r_run_open && (r_pix == r_run_color);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_pal_cnt   <= '0;
            r_run_color <= '0;
            r_run_index <= '0;
            r_run_count <= '0;
            r_run_open  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_pal_cnt   <= n_pal_cnt;
            r_run_color <= n_run_color;
            r_run_index <= n_run_index;
            r_run_count <= n_run_count;
            r_run_open  <= n_run_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_pix     <= n_pix;
        r_last    <= n_last;
        r_addr    <= n_addr;
        r_rd_addr <= n_rd_addr;
        r_found   <= n_found;
        r_idx     <= n_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_pix       = r_pix;
        n_last      = r_last;
        n_addr      = r_addr;
        n_rd_addr   = r_rd_addr;
        n_rd_vld    = 1'b0;
        n_found     = r_found;
        n_idx       = r_idx;
        n_pal_cnt   = r_pal_cnt;
        n_run_color = r_run_color;
        n_run_index = r_run_index;
        n_run_count = r_run_count;
        n_run_open  = r_run_open;

        o_stall     = (r_state != S_IDLE);
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pal_cnt[IDX_W-1:0];
        o_ram_wdata = r_pix;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_addr[IDX_W-1:0];
        o_push      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func  = i_func;
                    n_pix   = i_pixel[COLOR_W-1:0];
                    n_last  = i_last;
                    n_addr  = '0;
                    n_found = 1'b0;
                    // continuing run needs no palette lookup
                    if (i_func == FUNC_ENCODE && r_run_open &&
                        i_pixel[COLOR_W-1:0] == r_run_color) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_idx   = r_rd_addr;
                    n_state = S_COMMIT;
                end else if (r_addr < r_pal_cnt) begin
                    o_ram_re  = 1'b1;
                    n_rd_addr = r_addr[IDX_W-1:0];
                    n_rd_vld  = 1'b1;
                    n_addr    = CNT_W'(r_addr + 1'b1);
                end else begin
                    n_state = S_COMMIT;
                end
            end

            S_COMMIT: begin
                if (!i_fifo_full) begin
                    n_state = S_IDLE;
                    if (r_func == FUNC_PALETTE) begin
                        if (!r_found) begin
                            o_push.push          = 1'b1;
                            o_push.data.color    = PIX_W'(r_pix);
                            o_push.data.eoo      = r_last;
                            if (r_pal_cnt < CNT_W'(PALETTE_SIZE)) begin
                                o_ram_we          = 1'b1;
                                o_push.data.kind  = K_ENTRY;
                                o_push.data.index = IDX_OUT_W'(r_pal_cnt);
                                n_pal_cnt         = CNT_W'(r_pal_cnt + 1'b1);
                            end else begin
                                o_push.data.kind  = K_PAL_OVF;
                            end
                        end
                    end else begin
                        o_push.data.color = PIX_W'(r_run_color);
                        o_push.data.index = r_run_index;
                        if (same_run) begin
                            if (r_run_count == RUN_MAX) begin
                                // saturated run goes out, a new one starts
                                o_push.push            = 1'b1;
                                o_push.data.kind       = K_RUN_OVF;
                                o_push.data.run_length = LEN_W'(RUN_MAX);
                                n_run_count            = RUN_BITS'(1);
                            end else begin
                                n_run_count = RUN_BITS'(r_run_count + 1'b1);
                            end
                        end else begin
                            o_push.push            = r_run_open;
                            o_push.data.kind       = K_RUN;
                            o_push.data.run_length = LEN_W'(r_run_count);
                            n_run_color            = r_pix;
                            n_run_index            = r_found ? IDX_OUT_W'(r_idx) : '0;
                            n_run_count            = RUN_BITS'(1);
                            n_run_open             = 1'b1;
                        end
                        if (r_last) begin
                            n_state = S_LAST;
                        end
                    end
                end
            end

            S_LAST: begin
                if (!i_fifo_full) begin
                    o_push.push            = 1'b1;
                    o_push.data.kind       = K_RUN;
                    o_push.data.color      = PIX_W'(r_run_color);
                    o_push.data.index      = r_run_index;
                    o_push.data.run_length = LEN_W'(r_run_count);
                    o_push.data.eoo        = 1'b1;
                    n_run_open             = 1'b0;
                    n_run_count            = '0;
                    n_state                = S_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== design/palette_run_length_encoder_unit.sv =====
// Palette run-length encoder top: controller, palette RAM and result queue.
// Each pixel: S_IDLE takes it, S_SCAN reads palette entries until a hit (one RAM read per cycle,
// registered read data), S_COMMIT pushes the result, then S_LAST for the last pixel of an
// encode pass; a pixel that extends the open run skips S_SCAN. A full result queue holds S_COMMIT/S_LAST.
// New pixels are stalled outside S_IDLE. Reset (synchronous, active low) clears palette count, run
// state and queue; palette RAM contents are not cleared, entries at or above the count are unread.
`include "palette_run_length_encoder_unit_assert.svh"

module palette_run_length_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [prle_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_kind,
    output logic [prle_pkg::PIX_W-1:0]    o_color,
    output logic [prle_pkg::IDX_OUT_W-1:0] o_index,
    output logic [prle_pkg::LEN_W-1:0]    o_run_length,
    output logic                          o_end_of_output
);
    import prle_pkg::*;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [COLOR_W-1:0] ram_rdata;
    t_push              push;
    logic               fifo_full;
    t_result            head;

    prle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_pixel     (i_pixel),
        .i_last      (i_last),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_push      (push),
        .i_fifo_full (fifo_full)
    );

    prle_palette_ram #(
        .DEPTH (PALETTE_SIZE),
        .WIDTH (COLOR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    prle_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (fifo_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_kind          = head.kind;
    assign o_color         = head.color;
    assign o_index         = head.index;
    assign o_run_length    = head.run_length;
    assign o_end_of_output = head.eoo;

    // a palette insert always goes out as a palette entry result
    `PRLE_ASSERT_IMPL(a_wr_has_entry, i_clk, i_rst_n, ram_we, push.push && push.data.kind == K_ENTRY)
    // results are only pushed into a queue with room
    `PRLE_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, push.push, !fifo_full)
    // RAM is not read and written in the same cycle
    `PRLE_ASSERT_IMPL(a_no_rw_overlap, i_clk, i_rst_n, ram_we, !ram_re)
    // an accepted pixel keeps the block busy in the following cycle
    `PRLE_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

// ===== verif/tb_top.sv =====
// Testbench for palette_run_length_encoder_unit: directed palette/encode passes, then a random
// pixel stream, checked transfer by transfer against an in-bench model of the encoder.
// Depends on prle_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_top;
    import prle_pkg::*;

    localparam int TOTAL_PIXELS = 1500;
    localparam int MAX_GAP      = 5;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_func  = 1'b0;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 i_last  = 1'b0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [1:0]           o_kind;
    logic [PIX_W-1:0]     o_color;
    logic [IDX_OUT_W-1:0] o_index;
    logic [LEN_W-1:0]     o_run_length;
    logic                 o_end_of_output;

    palette_run_length_encoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_pixel         (i_pixel),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_color         (o_color),
        .o_index         (o_index),
        .o_run_length    (o_run_length),
        .o_end_of_output (o_end_of_output)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // encoder model state
    logic [PIX_W-1:0]     pal_mem [PALETTE_SIZE];
    int unsigned          pal_count = 0;
    logic [PIX_W-1:0]     run_color = '0;
    logic [IDX_OUT_W-1:0] run_index = '0;
    logic [RUN_BITS-1:0]  run_count = '0;
    logic                 run_open  = 1'b0;

    t_result     expected_results[$];
    int unsigned pixels_sent    = 0;
    int          mismatch_count = 0;
    bit          no_gaps        = 1'b0;
    int unsigned stall_left     = 0;

    function automatic int lookup_color(input logic [PIX_W-1:0] c);
        for (int i = 0; i < pal_count; i++) begin
            if (pal_mem[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic void push_result(input t_kind k, input logic [PIX_W-1:0] c,
                                        input logic [IDX_OUT_W-1:0] idx,
                                        input logic [LEN_W-1:0] len, input logic eoo);
        t_result r;
        r.kind       = k;
        r.color      = c;
        r.index      = idx;
        r.run_length = len;
        r.eoo        = eoo;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_pixel(input logic func, input logic [PIX_W-1:0] pix,
                                          input logic last);
        int hit;
        hit = lookup_color(pix);
        if (func == FUNC_PALETTE) begin
            if (hit < 0) begin
                if (pal_count < PALETTE_SIZE) begin
                    pal_mem[pal_count] = pix;
                    push_result(K_ENTRY, pix, IDX_OUT_W'(pal_count), '0, last);
                    pal_count++;
                end else begin
                    push_result(K_PAL_OVF, pix, '0, '0, last);
                end
            end
            return;
        end
        // saturation needs 2^RUN_BITS equal pixels; modeled, though not reached in this run
        if (run_open && pix == run_color) begin
            if (run_count == RUN_MAX) begin
                push_result(K_RUN_OVF, run_color, run_index, RUN_MAX, 1'b0);
                run_count = RUN_BITS'(1);
            end else begin
                run_count++;
            end
        end else begin
            if (run_open) push_result(K_RUN, run_color, run_index, run_count, 1'b0);
            run_color = pix;
            run_index = (hit < 0) ? '0 : IDX_OUT_W'(hit);
            run_count = RUN_BITS'(1);
            run_open  = 1'b1;
        end
        if (last) begin
            push_result(K_RUN, run_color, run_index, run_count, 1'b1);
            run_open  = 1'b0;
            run_count = '0;
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: kind %0d color %06h index %0d len %0d eoo %0d",
                         o_kind, o_color, o_index, o_run_length, o_end_of_output);
            return;
        end
        want = expected_results.pop_front();
        if (o_kind !== want.kind || o_color !== want.color || o_index !== want.index ||
            o_run_length !== want.run_length || o_end_of_output !== want.eoo) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch: exp kind %0d color %06h index %0d len %0d eoo %0d / %s",
                         want.kind, want.color, want.index, want.run_length, want.eoo,
                         $sformatf("got kind %0d color %06h index %0d len %0d eoo %0d",
                                   o_kind, o_color, o_index, o_run_length,
                                   o_end_of_output));
        end
    endtask

    // result side: take a transfer, then hold stall for a random number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            check_result();
            stall_left = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Entered right after a transfer edge (or reset release); returns at the transfer edge.
    task automatic send_pixel(input logic func, input logic [PIX_W-1:0] pix, input logic last);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_pixel <= pix;
        i_last  <= last;
        predict_pixel(func, pix, last);
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pixels_sent++;
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [PIX_W-1:0] pick_color(input int unsigned reuse_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (pal_count > 0 && roll < reuse_pct)
            return pal_mem[$urandom_range(0, pal_count - 1)];
        if (roll == 99) return '0;
        if (roll == 98) return '1;
        return PIX_W'($urandom());
    endfunction

    task automatic test_palette_entries();
        send_pixel(FUNC_PALETTE, 24'h000000, 1'b0);
        send_pixel(FUNC_PALETTE, 24'hFFFFFF, 1'b0);
        send_pixel(FUNC_PALETTE, 24'h000000, 1'b0);  // known color: silent
        send_pixel(FUNC_PALETTE, 24'h123456, 1'b1);
        send_pixel(FUNC_PALETTE, 24'hFFFFFF, 1'b1);  // last with nothing to emit
    endtask

    task automatic test_encode_runs();
        send_pixel(FUNC_ENCODE, 24'hFFFFFF, 1'b0);
        send_pixel(FUNC_ENCODE, 24'hFFFFFF, 1'b0);
        send_pixel(FUNC_ENCODE, 24'h000000, 1'b0);
        send_pixel(FUNC_ENCODE, 24'hABCDEF, 1'b0);   // not in palette -> index 0
        send_pixel(FUNC_ENCODE, 24'hABCDEF, 1'b0);
        send_pixel(FUNC_ENCODE, 24'h123456, 1'b1);   // closes two runs
        send_pixel(FUNC_ENCODE, 24'h000000, 1'b1);   // single-pixel pass
        send_pixel(FUNC_ENCODE, 24'h123456, 1'b0);
        send_pixel(FUNC_ENCODE, 24'h123456, 1'b1);   // last extends the open run
    endtask

    task automatic test_pass_interleave();
        // palette pixel inside an open run: run keeps the index it started with
        send_pixel(FUNC_ENCODE, 24'h555555, 1'b0);
        send_pixel(FUNC_PALETTE, 24'h555555, 1'b0);
        send_pixel(FUNC_ENCODE, 24'h555555, 1'b0);
        send_pixel(FUNC_ENCODE, 24'hAAAAAA, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_random_stream();
        int unsigned      len;
        int unsigned      runs;
        int unsigned      run_len;
        logic [PIX_W-1:0] c;
        bit               close;
        while (pixels_sent < TOTAL_PIXELS) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            close   = ($urandom_range(0, 5) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++)
                        send_pixel(FUNC_PALETTE, pick_color(40), close && i == len - 1);
                end
                4, 5, 6, 7, 8: begin
                    runs = $urandom_range(1, 8);
                    for (int r = 0; r < runs; r++) begin
                        c = pick_color(80);
                        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40)
                                                              : $urandom_range(1, 4);
                        for (int k = 0; k < run_len; k++)
                            send_pixel(FUNC_ENCODE, c,
                                       close && r == runs - 1 && k == run_len - 1);
                    end
                end
                default: begin
                    send_pixel(1'($urandom_range(0, 1)), pick_color(50),
                               1'($urandom_range(0, 1)));
                end
            endcase
            if ($urandom_range(0, 19) == 0) pause_until_drained();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_palette_entries();
        test_encode_runs();
        test_pass_interleave();
        test_random_stream();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
